### rtl/primed_stream_audio_mixer_defines.svh
// Assertion macros used by the checker file.
`ifndef PRIMED_STREAM_AUDIO_MIXER_DEFINES_SVH
`define PRIMED_STREAM_AUDIO_MIXER_DEFINES_SVH

// Assert that a property holds on every clock edge outside reset.
`define PSAM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert a property that must also hold while reset is active.
`define PSAM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/psam_pkg.sv
package psam_pkg;
    localparam int Slots      = 4;
    localparam int FifoFrames = 4096;
    localparam int SlotW      = 2;
    localparam int PtrW       = 12;
    localparam int FillW      = 13;
    localparam int AddrW      = SlotW + PtrW;
    localparam int MaxChunk   = 64;
    localparam int InW        = 56;  // tdata width of slave side
    localparam int OutW       = 40;  // tdata width of master side

    localparam logic [2:0] OpWrite     = 3'd0;
    localparam logic [2:0] OpOpen      = 3'd1;
    localparam logic [2:0] OpFinish    = 3'd2;
    localparam logic [2:0] OpFinishAll = 3'd3;
    localparam logic [2:0] OpTick      = 3'd4;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StFull  = 2'd1;
    localparam logic [1:0] StStale = 2'd2;

    localparam logic RegPrime = 1'b0;
    localparam logic RegChunk = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  slot;
        logic [15:0] generation;
        logic [15:0] left_in;
        logic [15:0] right_in;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_READ, S_ACC, S_EMIT, S_ANS
    } t_state;

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) return 16'h7fff;
        else if (v < -18'sd32768) return 16'h8000;
        else return v[15:0];
    endfunction
endpackage

### rtl/psam_ram.sv
module psam_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/psam_front.sv
// Accepts commands, drops ops 5..7, and holds the rest in a two-entry queue.
module psam_front import psam_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_cmd   i_cmd,
    output logic   o_valid,
    input  logic   i_ready,
    output t_cmd   o_cmd
);
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];
    assign push    = i_valid && o_ready && (i_cmd.op <= OpTick);  // unused ops dropped
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) r_rd <= ~r_rd;
        end
        if (push) r_q[r_rd ^ r_cnt[0]] <= i_cmd;
    end
endmodule

### rtl/psam_back.sv
// Executes commands: slot bookkeeping, FIFO writes, and mix ticks.
module psam_back import psam_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_cmd              i_cmd,
    input  logic [FillW-1:0]  i_prime,
    input  logic [6:0]        i_chunk,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [OutW-1:0]   o_tdata
);
    t_state                  r_state, n_state;
    t_cmd                    r_cmd;
    logic [PtrW-1:0]         r_rp   [Slots];
    logic [PtrW-1:0]         r_wp   [Slots];
    logic [FillW-1:0]        r_fill [Slots];
    logic [15:0]             r_gen  [Slots];
    logic [Slots-1:0]        r_use, r_prm, r_drn, r_join;
    logic [SlotW-1:0]        r_s;
    logic [6:0]              r_take, r_f;
    logic signed [17:0]      r_accl, r_accr;
    logic                    r_ovalid;
    logic [OutW-1:0]         r_odata;
    logic                    we;
    logic [AddrW-1:0]        waddr, raddr;
    logic [31:0]             rdata;
    logic                    out_free;
    logic                    load;
    logic [1:0]              ans_st;
    logic [6:0]              chunk_cap;

    psam_ram #(.Width(32), .Depth(Slots * FifoFrames)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr),
        .i_wdata({r_cmd.right_in, r_cmd.left_in}),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign out_free  = !r_ovalid || i_tready;
    assign load      = ((r_state == S_EMIT) || (r_state == S_ANS)) && out_free;
    assign o_tvalid  = r_ovalid;
    assign o_tdata   = r_odata;
    assign o_ready   = (r_state == S_IDLE);
    assign chunk_cap = (i_chunk > 7'(MaxChunk)) ? 7'(MaxChunk) : i_chunk;
    assign waddr     = {r_cmd.slot, r_wp[r_cmd.slot]};
    assign raddr     = {r_s, r_rp[r_s]};
    assign we        = (r_state == S_ANS) && (r_cmd.op == OpWrite) && out_free
                       && (ans_st == StOk);

    // Answer to a command; only writes can be refused.
    always_comb begin
        ans_st = StOk;
        if (r_cmd.op == OpWrite) begin
            if (!r_use[r_cmd.slot] || r_gen[r_cmd.slot] != r_cmd.generation)
                ans_st = StStale;
            else if (r_fill[r_cmd.slot] >= FillW'(FifoFrames))
                ans_st = StFull;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = (i_cmd.op == OpTick) ? S_SCAN : S_ANS;
            S_SCAN: if (r_s == SlotW'(Slots - 1)) n_state = S_READ;
            S_READ: begin
                if (r_join == '0 || r_take == '0) n_state = S_IDLE;
                else if (r_join[r_s]) n_state = S_ACC;
                else if (r_s == SlotW'(Slots - 1)) n_state = S_EMIT;
            end
            S_ACC:  n_state = (r_s == SlotW'(Slots - 1)) ? S_EMIT : S_READ;
            S_EMIT: if (out_free) n_state = (r_f + 7'd1 == r_take) ? S_IDLE : S_READ;
            S_ANS:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_use    <= '0;
            r_prm    <= '0;
            r_drn    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < Slots; i++) begin
                r_rp[i] <= '0; r_wp[i] <= '0; r_fill[i] <= '0; r_gen[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (load) r_ovalid <= 1'b1;
            else if (i_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_cmd  <= i_cmd;
                    r_s    <= '0;
                    r_join <= '0;
                    r_take <= chunk_cap;
                    r_f    <= '0;
                    r_accl <= '0;
                    r_accr <= '0;
                end
                S_SCAN: begin
                    if (r_use[r_s]) begin
                        if (r_drn[r_s]) begin
                            if (r_fill[r_s] == '0) r_use[r_s] <= 1'b0;
                            else begin
                                r_join[r_s] <= 1'b1;
                                if (r_fill[r_s] < FillW'(r_take)) r_take <= r_fill[r_s][6:0];
                            end
                        end else if (r_prm[r_s] || r_fill[r_s] >= i_prime) begin
                            r_prm[r_s]  <= 1'b1;
                            r_join[r_s] <= 1'b1;
                            if (r_fill[r_s] < FillW'(r_take)) r_take <= r_fill[r_s][6:0];
                        end
                    end
                    r_s <= r_s + 1'b1;
                end
                S_READ: if (!r_join[r_s] && r_join != '0 && r_take != '0) r_s <= r_s + 1'b1;
                S_ACC: begin
                    r_accl  <= r_accl + 18'(signed'(rdata[15:0]));
                    r_accr  <= r_accr + 18'(signed'(rdata[31:16]));
                    r_rp[r_s]   <= r_rp[r_s] + 1'b1;
                    r_fill[r_s] <= r_fill[r_s] - 1'b1;
                    r_s     <= r_s + 1'b1;
                end
                S_EMIT: if (out_free) begin
                    r_odata <= {4'd0, sat16(r_accr), sat16(r_accl), StOk,
                                (r_f + 7'd1 == r_take), 1'b1};
                    r_f    <= r_f + 7'd1;
                    r_accl <= '0;
                    r_accr <= '0;
                    r_s    <= '0;
                end
                S_ANS: if (out_free) begin
                    r_odata <= {4'd0, 32'd0, ans_st, 1'b1, 1'b0};
                    case (r_cmd.op)
                        OpWrite: if (ans_st == StOk) begin
                            r_wp[r_cmd.slot]   <= r_wp[r_cmd.slot] + 1'b1;
                            r_fill[r_cmd.slot] <= r_fill[r_cmd.slot] + 1'b1;
                        end
                        OpOpen: begin
                            r_gen[r_cmd.slot]  <= r_cmd.generation;
                            r_rp[r_cmd.slot]   <= '0;
                            r_wp[r_cmd.slot]   <= '0;
                            r_fill[r_cmd.slot] <= '0;
                            r_prm[r_cmd.slot]  <= 1'b0;
                            r_drn[r_cmd.slot]  <= 1'b0;
                            r_use[r_cmd.slot]  <= 1'b1;
                        end
                        OpFinish: if (r_use[r_cmd.slot]) r_drn[r_cmd.slot] <= 1'b1;
                        OpFinishAll: r_drn <= r_drn | r_use;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/primed_stream_audio_mixer.sv
// Primed multi-stream stereo PCM mixer, four slots of 4096-frame FIFOs.
// Slave stream carries commands: write frame, open, finish, finish all,
// mix tick (tuser = op). Ops 5..7 are dropped without an answer.
// Master stream returns results: tuser = kind (0 status, 1 mixed frame),
// tdata = status, left, right; tlast marks the final result of a command.
// Config channel writes the prime threshold (index 0) and the chunk size
// (index 1); write it only while no command is in flight.
// Flow: a command waits in a two-entry queue, then a non-tick command gets a
// status answer. A mix tick scans the four slots and then, per frame, reads and
// accumulates each joining slot in turn and emits the frame once the output
// register is free; the reads are serialised by the single read port of the
// frame store.
// Reset clears slot state and configuration to 480 / 64; the frame store is
// not cleared and needs no sweep. A stalled receiver holds the output
// register; the back end waits and the queue keeps taking commands until full.
module primed_stream_audio_mixer import psam_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [2:0]      s_axis_tuser,   // op
    input  logic [InW-1:0]  s_axis_tdata,   // slot[1:0], generation[17:2],
                                            // left_in[33:18], right_in[49:34], pad
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic            m_axis_tuser,   // kind
    output logic [OutW-1:0] m_axis_tdata,   // status[1:0], left_out[17:2],
                                            // right_out[33:18], pad
    output logic            m_axis_tlast,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_index,
    input  logic [12:0]     i_cfg_data
);
    logic [FillW-1:0] r_prime;
    logic [6:0]       r_chunk;
    t_cmd             in_cmd, q_cmd;
    logic             q_valid, q_ready;
    logic [OutW-1:0]  odata;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime <= 13'd480;
            r_chunk <= 7'd64;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == RegPrime) r_prime <= i_cfg_data;
            if (i_cfg_index == RegChunk) r_chunk <= i_cfg_data[6:0];
        end
    end

    assign in_cmd = '{op: s_axis_tuser, slot: s_axis_tdata[1:0],
                      generation: s_axis_tdata[17:2], left_in: s_axis_tdata[33:18],
                      right_in: s_axis_tdata[49:34]};

    psam_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    psam_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .i_prime(r_prime), .i_chunk(r_chunk),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready), .o_tdata(odata)
    );

    // odata: kind[0], last[1], status[3:2], left[19:4], right[35:20]
    assign m_axis_tuser = odata[0];
    assign m_axis_tlast = odata[1];
    assign m_axis_tdata = {6'd0, odata[35:4], odata[3:2]};
endmodule

### rtl/psam_checker.sv
`include "primed_stream_audio_mixer_defines.svh"
module psam_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast,
    input logic [39:0] m_axis_tdata
);
    logic        st_beat, mix_beat;
    logic [1:0]  st_bits;
    logic [31:0] samples;

    assign st_beat  = m_axis_tvalid && !m_axis_tuser;
    assign mix_beat = m_axis_tvalid && m_axis_tuser;
    assign st_bits  = m_axis_tdata[1:0];
    assign samples  = m_axis_tdata[33:2];

    `PSAM_ASSERT(a_status_tlast, i_clk, i_rst_n, st_beat |-> m_axis_tlast, "status not last")
    `PSAM_ASSERT(a_status_zero, i_clk, i_rst_n, st_beat |-> (samples == '0), "status samples set")
    `PSAM_ASSERT(a_mix_ok, i_clk, i_rst_n, mix_beat |-> (st_bits == 2'd0), "mix status nonzero")
    `PSAM_ASSERT(a_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "valid dropped")
    `PSAM_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
endmodule

bind primed_stream_audio_mixer psam_checker u_chk (.*);

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import psam_pkg::*;

    localparam int CycleLimit = 1500000;
    localparam int IdleWait   = 40;   // margin for the queue and the tick scan

    // One expected output transaction.
    typedef struct {
        bit          kind;
        logic [1:0]  status;
        logic [15:0] left_s;
        logic [15:0] right_s;
        bit          last;
    } t_mix_result;

    // Scoreboard: tracks slot state and predicts the mixer output.
    class t_mixer_scoreboard;
        logic [31:0] slot_frames[Slots][$];  // {right, left} per frame
        bit          in_use[Slots];
        bit          primed[Slots];
        bit          draining[Slots];
        logic [15:0] slot_gen[Slots];
        int          prime_cfg;
        int          chunk_cfg;
        t_mix_result want_q[$];
        int          errors;

        function new();
            prime_cfg = 480;
            chunk_cfg = 64;
            errors    = 0;
            for (int s = 0; s < Slots; s++) begin
                in_use[s] = 0; primed[s] = 0; draining[s] = 0; slot_gen[s] = '0;
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void write_reg(logic idx, logic [12:0] val);
            if (idx == RegPrime) prime_cfg = int'(val);
            else                 chunk_cfg = int'(val[6:0]);
        endfunction

        function logic [15:0] clip16(int v);
            if (v > 32767)  return 16'h7fff;
            if (v < -32768) return 16'h8000;
            return v[15:0];
        endfunction

        function void push_status(logic [1:0] st);
            t_mix_result r;
            r.kind = 0; r.status = st; r.left_s = '0; r.right_s = '0; r.last = 1;
            want_q.push_back(r);
        endfunction

        function void run_tick();
            bit joins[Slots];
            int take, njoin, accl, accr;
            logic [31:0] w;
            t_mix_result r;
            take  = (chunk_cfg > MaxChunk) ? MaxChunk : chunk_cfg;
            njoin = 0;
            for (int s = 0; s < Slots; s++) begin
                joins[s] = 0;
                if (!in_use[s]) continue;
                if (draining[s]) begin
                    if (slot_frames[s].size() == 0) begin
                        in_use[s] = 0;   // drained stream is released
                        continue;
                    end
                end else if (!primed[s]) begin
                    if (slot_frames[s].size() >= prime_cfg) primed[s] = 1;
                    else continue;
                end
                joins[s] = 1;
                njoin++;
                if (slot_frames[s].size() < take) take = slot_frames[s].size();
            end
            if (njoin == 0 || take == 0) return;
            for (int f = 0; f < take; f++) begin
                accl = 0; accr = 0;
                for (int s = 0; s < Slots; s++) begin
                    if (!joins[s]) continue;
                    w = slot_frames[s].pop_front();
                    accl += int'($signed(w[15:0]));
                    accr += int'($signed(w[31:16]));
                end
                r.kind = 1; r.status = StOk;
                r.left_s = clip16(accl); r.right_s = clip16(accr);
                r.last = (f == take - 1);
                want_q.push_back(r);
            end
        endfunction

        // Called for every accepted command transaction.
        function void note_command(logic [2:0] op, logic [1:0] slot, logic [15:0] gen,
                                   logic [15:0] l, logic [15:0] r);
            case (op)
                OpTick: run_tick();
                OpFinishAll: begin
                    for (int s = 0; s < Slots; s++) if (in_use[s]) draining[s] = 1;
                    push_status(StOk);
                end
                OpWrite: begin
                    if (!in_use[slot] || slot_gen[slot] != gen) push_status(StStale);
                    else if (slot_frames[slot].size() >= FifoFrames) push_status(StFull);
                    else begin
                        slot_frames[slot].push_back({r, l});
                        push_status(StOk);
                    end
                end
                OpOpen: begin
                    slot_gen[slot] = gen;
                    slot_frames[slot].delete();
                    primed[slot] = 0; draining[slot] = 0; in_use[slot] = 1;
                    push_status(StOk);
                end
                OpFinish: begin
                    if (in_use[slot]) draining[slot] = 1;
                    push_status(StOk);
                end
                default: ;  // ops 5..7 are dropped silently
            endcase
        endfunction

        function void check_result(bit kind, logic [1:0] st, logic [15:0] l,
                                   logic [15:0] r, bit last);
            t_mix_result e;
            if (want_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output: kind %0d status %0d L %h R %h last %0d",
                             kind, st, l, r, last);
                return;
            end
            e = want_q.pop_front();
            if (e.kind !== kind || e.status !== st || e.left_s !== l ||
                e.right_s !== r || e.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp kind %0d st %0d L %h R %h last %0d, got %0d %0d %h %h %0d",
                             e.kind, e.status, e.left_s, e.right_s, e.last,
                             kind, st, l, r, last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser;    // op
    logic [55:0] s_axis_tdata;    // slot, generation, left_in, right_in, pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        m_axis_tuser;    // kind
    logic [39:0] m_axis_tdata;    // status, left_out, right_out, pad
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [12:0] i_cfg_data;

    t_mixer_scoreboard sb = new();

    int cycle_count  = 0;
    int hold_request = 0;  // bumped by stimulus to ask for a long receiver hold-off

    primed_stream_audio_mixer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 0;
    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Gap length: mostly none or short, occasionally long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver side: checks every output transaction, drives tready with
    // random stalls plus the long hold-off on request.
    initial begin
        int stall;
        int hold;
        int served;
        stall = 0; hold = 0; served = 0;
        m_axis_tready = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[17:2],
                                m_axis_tdata[33:18], m_axis_tlast);
            if (served != hold_request) begin
                served = hold_request;
                hold   = 3000;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 0;
            end else begin
                stall = pick_gap();
                m_axis_tready <= (stall == 0) ? 1'b1 : 1'b0;
            end
            @(posedge i_clk);
        end
    end

    // One command transaction; the sender gap is taken first.
    task automatic send_cmd(logic [2:0] op, logic [1:0] slot, logic [15:0] gen,
                            logic [15:0] l, logic [15:0] r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, r, l, gen, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(op, slot, gen, l, r);
    endtask

    // Stop sending and let all expected results drain.
    task automatic drain_all();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (IdleWait) @(posedge i_clk);
    endtask

    // Register write; only called when the mixer is idle.
    task automatic write_cfg(logic idx, logic [12:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // One random command, mostly well-formed stream traffic.
    task automatic random_cmd();
        int r;
        logic [1:0] s;
        logic [15:0] g;
        r = $urandom_range(0, 99);
        s = 2'($urandom_range(0, 3));
        g = sb.slot_gen[s];
        if (r < 50) begin
            if (!sb.in_use[s] && $urandom_range(0, 1))
                send_cmd(OpOpen, s, 16'($urandom), '0, '0);
            else
                send_cmd(OpWrite, s, g, 16'($urandom), 16'($urandom));
        end else if (r < 56)
            send_cmd(OpWrite, s, 16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 64)
            send_cmd(OpOpen, s, 16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 69)
            send_cmd(OpFinish, s, 16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 71)
            send_cmd(OpFinishAll, s, 16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 95)
            send_cmd(OpTick, s, 16'($urandom), 16'($urandom), 16'($urandom));
        else
            send_cmd(3'($urandom_range(5, 7)), s, 16'($urandom), 16'($urandom),
                     16'($urandom));
    endtask

    initial begin
        i_rst_n       = 0;
        s_axis_tvalid = 0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 0;
        i_cfg_index   = 0;
        i_cfg_data    = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: priming, saturation both ways, stale writes, finish paths.
        write_cfg(RegPrime, 13'd1);
        write_cfg(RegChunk, 13'd4);
        send_cmd(OpTick, 2'd0, '0, '0, '0);             // nothing open: silent
        send_cmd(OpOpen, 2'd0, 16'h0000, '0, '0);
        send_cmd(OpOpen, 2'd1, 16'hffff, '0, '0);
        send_cmd(OpOpen, 2'd2, 16'h1234, '0, '0);
        send_cmd(OpOpen, 2'd3, 16'h8000, '0, '0);
        for (int s = 0; s < Slots; s++)
            send_cmd(OpWrite, 2'(s), sb.slot_gen[s], 16'h7fff, 16'h8000);
        send_cmd(OpWrite, 2'd0, 16'h0000, 16'h8000, 16'h7fff);
        send_cmd(OpTick, 2'd0, '0, '0, '0);             // all four saturate
        send_cmd(OpWrite, 2'd0, 16'h0001, 16'h0001, 16'h0001);  // stale generation
        send_cmd(OpWrite, 2'd1, 16'hffff, 16'hffff, 16'h0001);
        send_cmd(OpFinish, 2'd1, '0, '0, '0);
        send_cmd(OpFinishAll, 2'd0, '0, '0, '0);
        send_cmd(OpTick, 2'd0, '0, '0, '0);             // draining slots play out
        send_cmd(OpTick, 2'd0, '0, '0, '0);             // empty drained slots freed
        send_cmd(OpWrite, 2'd1, 16'hffff, '0, '0);      // freed slot: rejected
        send_cmd(OpFinish, 2'd2, '0, '0, '0);           // unused slot: no change
        send_cmd(3'd5, 2'd0, '0, '0, '0);
        send_cmd(3'd6, 2'd1, '0, '0, '0);
        send_cmd(3'd7, 2'd3, 16'hffff, 16'hffff, 16'hffff);
        drain_all();

        // Buffer more than a chunk in one FIFO, then take a full chunk.
        write_cfg(RegChunk, 13'd64);
        send_cmd(OpOpen, 2'd0, 16'h5a5a, '0, '0);
        for (int i = 0; i < MaxChunk + 6; i++)
            send_cmd(OpWrite, 2'd0, 16'h5a5a, 16'($urandom), 16'($urandom));
        send_cmd(OpTick, 2'd0, '0, '0, '0);
        drain_all();

        // Random phases under different register settings.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_cfg(RegPrime, 13'($urandom_range(1, 6)));
                         write_cfg(RegChunk, 13'($urandom_range(1, 64))); end
                1: begin write_cfg(RegPrime, 13'd0); write_cfg(RegChunk, 13'd0); end
                2: begin write_cfg(RegPrime, 13'd8191); write_cfg(RegChunk, 13'd127); end
                default: begin write_cfg(RegPrime, 13'd3); write_cfg(RegChunk, 13'd1); end
            endcase
            for (int s = 0; s < Slots; s++) send_cmd(OpOpen, 2'(s), 16'($urandom), '0, '0);
            for (int i = 0; i < 12; i++) begin
                // Long receiver hold-off mid-phase; commands back up in the queue.
                if (ph == 0 && i == 4) hold_request++;
                random_cmd();
            end
            drain_all();
        end

        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### primed_stream_audio_mixer.f
+incdir+rtl
rtl/psam_pkg.sv
rtl/psam_ram.sv
rtl/psam_front.sv
rtl/psam_back.sv
rtl/primed_stream_audio_mixer.sv
rtl/psam_checker.sv
test/tb_top.sv
